@@ sv/rdt_pkg.sv @@
// ============================================================================
// rdt_pkg - shared types and constants for the definition tagger
// Item kinds, scanner modes, queue sizing and the keyword classifier.
// ============================================================================
package rdt_pkg;

    // Longest identifier before it is closed
    localparam int MAX_TOKEN    = 128;
    // Number of identifier characters kept for keyword matching
    localparam int PREFIX_DEPTH = 6;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_DEPTH);

    localparam int LINE_W         = 24;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Result word layout
    localparam int KIND_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int M_DATA_W = ((KIND_W + CHAR_W + LINE_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - (KIND_W + CHAR_W + LINE_W);

    // Decoupling queue between scanner and emitter
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR    = 3'd0,
        KIND_CLASS   = 3'd1,
        KIND_MODULE  = 3'd2,
        KIND_METHOD  = 3'd3,
        KIND_REF     = 3'd4,
        KIND_DROPPED = 3'd5
    } kind_t;

    // Scanner mode, one-hot
    typedef enum logic [6:0] {
        MODE_NORMAL  = 7'b0000001,
        MODE_IDENT   = 7'b0000010,
        MODE_DQUOTE  = 7'b0000100,
        MODE_SQUOTE  = 7'b0001000,
        MODE_COMMENT = 7'b0010000,
        MODE_PAREN   = 7'b0100000,
        MODE_BRACKET = 7'b1000000
    } mode_t;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_DROP,
        ROLE_CLASS,
        ROLE_MODULE,
        ROLE_DEF
    } role_t;

    // First characters of the identifier, entry 0 in the top bits
    typedef logic [0:PREFIX_DEPTH-1][7:0] prefix_t;

    // Everything one input byte produces: optional char, optional verdict
    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] char_val;
        logic              has_verdict;
        kind_t             verdict_kind;
        logic [LINE_W-1:0] line;
    } packet_t;

    // Keyword lookup on the stored prefix and the identifier length
    function automatic role_t kw_role(input logic [7:0] len, input prefix_t p);
        role_t r;
        r = ROLE_NONE;
        if ((len == 8'd5 && p[0:4] == "while") ||
            (len == 8'd3 && p[0:2] == "end")   ||
            (len == 8'd4 && p[0:3] == "case")  ||
            (len == 8'd3 && p[0:2] == "for")   ||
            (len == 8'd2 && p[0:1] == "if")    ||
            (len == 8'd4 && p[0:3] == "else")  ||
            (len == 8'd5 && p[0:4] == "elsif"))
            r = ROLE_DROP;
        else if (len == 8'd5 && p[0:4] == "class")
            r = ROLE_CLASS;
        else if (len == 8'd6 && p[0:5] == "module")
            r = ROLE_MODULE;
        else if (len == 8'd3 && p[0:2] == "def")
            r = ROLE_DEF;
        return r;
    endfunction

endpackage

@@ sv/rdt_scanner.sv @@
// ============================================================================
// rdt_scanner - front end: byte classification and identifier tracking
// Handles one byte per cycle while in_fire is high and forms at most one packet of results per byte.
// ============================================================================
module rdt_scanner import rdt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    input  logic              in_eot,
    output packet_t           pkt,
    output logic              pkt_push
);

    mode_t             mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [7:0]        len_reg, len_next;
    prefix_t           prefix_reg, prefix_next;
    logic              pend_class_reg, pend_class_next;
    logic              pend_module_reg, pend_module_next;
    logic              pend_method_reg, pend_method_next;

    logic       is_alpha, is_digit, is_idch, is_nl;
    logic [7:0] len_inc;
    prefix_t    prefix_wr, prefix_start;
    logic       ident_char;
    logic [7:0] vlen;
    prefix_t    vprefix;
    role_t      role;
    logic       emit_char, emit_verdict, do_normal, bump;
    kind_t      verdict_kind;

    // Character classes
    assign is_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
    assign is_digit = (in_byte >= "0" && in_byte <= "9");
    assign is_idch  = is_alpha || is_digit || (in_byte == "_");
    assign is_nl    = (in_byte == 8'h0A);

    assign len_inc    = len_reg + 8'd1;
    assign ident_char = !in_eot && (mode_reg == MODE_IDENT) && is_idch;

    // Prefix with the incoming char written at the current length
    always_comb begin
        prefix_wr = prefix_reg;
        if (len_reg < 8'(PREFIX_DEPTH)) begin
            prefix_wr[len_reg[PREFIX_IDX_W-1:0]] = in_byte;
        end
        prefix_start    = prefix_reg;
        prefix_start[0] = in_byte;
    end

    // Keyword match sees the identifier including a char of this cycle
    assign vlen    = ident_char ? len_inc : len_reg;
    assign vprefix = ident_char ? prefix_wr : prefix_reg;
    assign role    = kw_role(vlen, vprefix);

    // Next state
    always_comb begin
        mode_next        = mode_reg;
        line_next        = line_reg;
        len_next         = len_reg;
        prefix_next      = prefix_reg;
        pend_class_next  = pend_class_reg;
        pend_module_next = pend_module_reg;
        pend_method_next = pend_method_reg;
        emit_char        = 1'b0;
        emit_verdict     = 1'b0;
        do_normal        = 1'b0;
        bump             = 1'b0;
        verdict_kind     = KIND_REF;

        if (in_fire) begin
            if (in_eot) begin
                emit_verdict = (mode_reg == MODE_IDENT);
            end else begin
                unique case (mode_reg)
                    MODE_IDENT: begin
                        if (is_idch) begin
                            emit_char   = 1'b1;
                            len_next    = len_inc;
                            prefix_next = prefix_wr;
                            if (len_inc >= 8'(MAX_TOKEN)) emit_verdict = 1'b1;
                        end else begin
                            emit_verdict = 1'b1;
                            do_normal    = 1'b1;
                        end
                    end
                    MODE_DQUOTE: begin
                        bump = is_nl;
                        if (in_byte == 8'h22) mode_next = MODE_NORMAL;
                    end
                    MODE_SQUOTE: begin
                        bump = is_nl;
                        if (in_byte == 8'h27) mode_next = MODE_NORMAL;
                    end
                    MODE_COMMENT: begin
                        if (is_nl) begin
                            bump      = 1'b1;
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_PAREN: begin
                        bump = is_nl;
                        if (in_byte == ")") mode_next = MODE_NORMAL;
                    end
                    MODE_BRACKET: begin
                        bump = is_nl;
                        if (in_byte == "]") mode_next = MODE_NORMAL;
                    end
                    default: do_normal = 1'b1;
                endcase
            end
        end

        // Verdict closes the identifier and settles the pending flags
        if (emit_verdict) begin
            len_next  = 8'd0;
            mode_next = MODE_NORMAL;
            if (role != ROLE_NONE) begin
                verdict_kind = KIND_DROPPED;
                if (role == ROLE_CLASS)  pend_class_next  = 1'b1;
                if (role == ROLE_MODULE) pend_module_next = 1'b1;
                if (role == ROLE_DEF)    pend_method_next = 1'b1;
            end else if (pend_class_reg) begin
                verdict_kind    = KIND_CLASS;
                pend_class_next = 1'b0;
            end else if (pend_module_reg) begin
                verdict_kind     = KIND_MODULE;
                pend_module_next = 1'b0;
            end else if (pend_method_reg) begin
                verdict_kind     = KIND_METHOD;
                pend_method_next = 1'b0;
            end
        end

        // Plain text scanning; an identifier start only occurs from normal mode
        if (do_normal) begin
            if (is_nl) begin
                bump = 1'b1;
            end else if (in_byte == 8'h22) begin
                mode_next = MODE_DQUOTE;
            end else if (in_byte == 8'h27) begin
                mode_next = MODE_SQUOTE;
            end else if (in_byte == "#") begin
                mode_next = MODE_COMMENT;
            end else if (in_byte == "(") begin
                mode_next = MODE_PAREN;
            end else if (in_byte == "[") begin
                mode_next = MODE_BRACKET;
            end else if (is_alpha || in_byte == "_") begin
                emit_char   = 1'b1;
                len_next    = 8'd1;
                prefix_next = prefix_start;
                mode_next   = MODE_IDENT;
            end
        end

        // Saturating line counter
        if (bump && line_reg != LINE_MAX) line_next = line_reg + 1'b1;

        // End of text returns to the reset state
        if (in_fire && in_eot) begin
            mode_next        = MODE_NORMAL;
            line_next        = LINE_W'(1);
            len_next         = 8'd0;
            pend_class_next  = 1'b0;
            pend_module_next = 1'b0;
            pend_method_next = 1'b0;
        end
    end

    // Packet toward the queue; both results of a byte share the current line
    always_comb begin
        pkt.has_char     = emit_char;
        pkt.char_val     = in_byte;
        pkt.has_verdict  = emit_verdict;
        pkt.verdict_kind = verdict_kind;
        pkt.line         = line_reg;
    end
    assign pkt_push = in_fire && (emit_char || emit_verdict);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_NORMAL;
            line_reg        <= LINE_W'(1);
            len_reg         <= 8'd0;
            pend_class_reg  <= 1'b0;
            pend_module_reg <= 1'b0;
            pend_method_reg <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            line_reg        <= line_next;
            len_reg         <= len_next;
            pend_class_reg  <= pend_class_next;
            pend_module_reg <= pend_module_next;
            pend_method_reg <= pend_method_next;
        end
    end

    // Prefix bytes need no reset
    always_ff @(posedge aclk) begin
        prefix_reg <= prefix_next;
    end

`ifndef ASSERT_OFF
    // Line counter never reaches zero
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0) else $error("line counter is zero");

    // Identifier length stays below the cutoff
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg < 8'(MAX_TOKEN)) else $error("identifier length overran");

    // Outside an identifier no length is held
    a_len_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_IDENT |-> len_reg == 8'd0)
        else $error("length held outside identifier");
`endif

endmodule

@@ sv/rdt_queue.sv @@
// ============================================================================
// rdt_queue - short packet queue between scanner and emitter
// Register based FIFO; head entry is read from the register array.
// ============================================================================
module rdt_queue import rdt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  packet_t push_pkt,
    input  logic    pop,
    output packet_t head_pkt,
    output logic    head_valid,
    output logic    full
);

    packet_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_pkt   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_pkt;
    end

`ifndef ASSERT_OFF
    // Fill level stays within depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH)) else $error("queue overfilled");

    // A lone push raises the fill level by one
    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not track push");
`endif

endmodule

@@ sv/rdt_emitter.sv @@
// ============================================================================
// rdt_emitter - back end: turns queued packets into result words
// A packet yields its char word, then its verdict word, each if present, one per handshake.
// ============================================================================
module rdt_emitter import rdt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  packet_t             head_pkt,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    // Set once the char of a two-word packet has gone out
    logic  phase_reg, phase_next;
    logic  show_char, fire;
    kind_t kind;

    assign show_char = head_pkt.has_char && !phase_reg;
    assign kind      = show_char ? KIND_CHAR : head_pkt.verdict_kind;
    assign fire      = m_tvalid && m_tready;
    assign pop       = fire && (!show_char || !head_pkt.has_verdict);

    assign m_tvalid = head_valid;
    assign m_tlast  = !show_char;
    assign m_tdata  = {{M_PAD_W{1'b0}}, head_pkt.line,
                       show_char ? head_pkt.char_val : 8'h00, kind};

    always_comb begin
        phase_next = phase_reg;
        if (pop)       phase_next = 1'b0;
        else if (fire) phase_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) phase_reg <= 1'b0;
        else          phase_reg <= phase_next;
    end

`ifndef ASSERT_OFF
    // Second phase only while a packet with a verdict waits
    a_phase_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid && head_pkt.has_char && head_pkt.has_verdict)
        else $error("verdict phase without matching packet");
`endif

endmodule

@@ sv/ruby_definition_tagger_unit.sv @@
// ============================================================================
// ruby_definition_tagger_unit - identifier and definition tagger, top level
// Scanner front end, packet queue and word emitter joined by stream ports.
// ============================================================================
// Path: a result word is offered from the packet queue, which registers the packet of its byte.
// Throughput: one byte per cycle while the four-entry packet queue has room;
//   a byte that yields a char and a verdict gives two output words.
// Reset: synchronous, active low; clears mode, line count (to one), length,
//   pending flags and the queue at once; the prefix bytes are not reset.
module ruby_definition_tagger_unit import rdt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] text_byte
    input  logic                s_tlast,   // end_of_text
    // master side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [2:0] item_kind, [10:3] token_char,
                                           // [34:11] line_number, rest zero
    output logic                m_tlast    // run_last
);

    packet_t pkt, head_pkt;
    logic    pkt_push, q_full, head_valid, pop, in_fire;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    rdt_scanner u_scanner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_tdata),
        .in_eot   (s_tlast),
        .pkt      (pkt),
        .pkt_push (pkt_push)
    );

    rdt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (pkt_push),
        .push_pkt   (pkt),
        .pop        (pop),
        .head_pkt   (head_pkt),
        .head_valid (head_valid),
        .full       (q_full)
    );

    rdt_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_pkt   (head_pkt),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
